FILE: rtl/hall_commutation_angle_speed_top_defines.svh
// Assertion macros for the hall decoder checker.
// No dependencies.
`ifndef HALL_COMMUTATION_ANGLE_SPEED_TOP_DEFINES_SVH
`define HALL_COMMUTATION_ANGLE_SPEED_TOP_DEFINES_SVH
// implication checked on every clock, disabled in reset
`define HCAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcas check failed");
// next-cycle implication
`define HCAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcas check failed");
`endif

FILE: rtl/hcas_pkg.sv
// Package for the hall decoder: widths, constants and sequencer states.
// No dependencies.
package hcas_pkg;
  localparam int StepAngle  = 75;
  localparam int FullTurn   = 3600;
  localparam int PhaseLimit = 75;
  localparam int NumW       = 18;
  localparam int PerW       = 16;

  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegStall    = 2'd1;
  localparam logic [1:0] RegNum      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_OUT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [NumW-1:0]        dividend;
    logic [PerW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [NumW-1:0]        quotient;
  } div_rsp_t;
endpackage

FILE: rtl/hcas_if.sv
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing; payload width given by parameter.
interface hcas_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hall_commutation_angle_speed_top.sv
// Hall sensor sector, angle and speed decoder.
// A sample beat with no sector step passes through ST_MUL1, ST_MUL2 and ST_MUL3
// to ST_OUT; one with a step first waits in ST_DIV for the serial divider.
// No new sample is taken until the result beat is taken; not ready meanwhile.
// Synchronous active-high reset restores the configuration and architectural
// registers to defaults and seeds sector tracking from the first sample.
module hall_commutation_angle_speed_top (
  input  logic clk,
  input  logic rst,
  hcas_if.sink   in_ch,
  hcas_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcas_pkg::*;

  // configuration registers
  logic [3:0]      debounce_count;
  logic [15:0]     stall_ticks;
  logic [NumW-1:0] speed_numerator;
  logic            wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count  <= 4'd4;
      stall_ticks     <= 16'd30000;
      speed_numerator <= 18'd62500;
    end else if (wr) begin
      case (paddr[3:2])
        RegDebounce: debounce_count  <= pwdata[3:0];
        RegStall:    stall_ticks     <= pwdata[15:0];
        RegNum:      speed_numerator <= pwdata[NumW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDebounce: prdata = {28'd0, debounce_count};
      RegStall:    prdata = {16'd0, stall_ticks};
      RegNum:      prdata = {14'd0, speed_numerator};
      default:     prdata = '0;
    endcase
  end

  // architectural state
  logic [2:0]  decoded_code, previous_decoded, accepted_sector, prior_sector;
  logic [3:0]  repeat_count;
  logic        sector_unknown, first_run;
  logic signed [12:0] angle_reg;
  logic signed [15:0] speed_reg, speed_before;
  logic [15:0] period_count;

  state_t state, state_next;

  // per-sample working registers
  logic signed [3:0] dir;
  logic [15:0]       period_use;
  logic [2:0]        sect_out;
  logic [31:0]       prod;
  logic              neg_s;
  logic              ph_clamp;
  logic [11:0]       ph_mid;
  logic signed [7:0] phase;

  // combinational front end of one sample
  logic [2:0]  code, dec, acc_n, pri_n;
  logic [3:0]  rep_n, rep_inc;
  logic [16:0] per_sum;
  logic [15:0] per_sat;
  logic signed [3:0] d_raw, d_w;
  logic signed [13:0] ang_sum;
  logic signed [12:0] ang_n;

  always_comb begin
    code    = {in_ch.data[10], in_ch.data[9], in_ch.data[8]};
    per_sum = {1'b0, period_count} + {9'd0, in_ch.data[7:0]};
    per_sat = per_sum[16] ? 16'hFFFF : per_sum[15:0];
    case (code)
      3'd1:    dec = 3'd5;
      3'd5:    dec = 3'd4;
      3'd4:    dec = 3'd3;
      3'd6:    dec = 3'd2;
      3'd2:    dec = 3'd1;
      3'd3:    dec = 3'd0;
      default: dec = decoded_code;
    endcase
    acc_n = sector_unknown ? dec : accepted_sector;
    pri_n = sector_unknown ? dec : prior_sector;
    rep_inc = repeat_count + 4'd1;
    rep_n = 4'd0;
    if (dec != pri_n && dec == previous_decoded) begin
      rep_n = rep_inc;
      if (rep_inc >= debounce_count) begin
        rep_n = 4'd0;
        acc_n = dec;
      end
    end
    d_raw = $signed({1'b0, acc_n}) - $signed({1'b0, pri_n});
    d_w = d_raw;
    if (d_raw <= -4'sd5) d_w = d_raw + 4'sd6;
    else if (d_raw >= 4'sd5) d_w = d_raw - 4'sd6;
    ang_sum = 14'(angle_reg) + 14'(d_w) * 14'sd75;
    ang_n = angle_reg;
    if (d_w != 0) begin
      if (ang_sum >= 14'sd3600) ang_n = 13'(ang_sum - 14'sd3600);
      else if (ang_sum < 0)     ang_n = 13'(ang_sum + 14'sd3600);
      else                      ang_n = 13'(ang_sum);
    end
    if (code == 3'd0) ang_n = -13'sd1;
    if (d_w <= -4'sd2 || d_w >= 4'sd2) ang_n = -13'sd2;
  end

  // serial divider for the speed quotient
  div_req_t dreq;
  div_rsp_t drsp;
  hcas_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [15:0] per_clamp;
  assign per_clamp = (per_sat > stall_ticks) ? stall_ticks : per_sat;
  assign dreq.start    = (state == ST_IDLE) && in_ch.valid && (d_w != 0);
  assign dreq.dividend = speed_numerator;
  assign dreq.divisor  = (per_clamp == 16'd0) ? 16'd1 : per_clamp;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid) state_next = (d_w != 0) ? ST_DIV : ST_MUL1;
      ST_DIV:  if (drsp.done) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = (state == ST_OUT);
    out_ch.data  = {sect_out, dir, angle_reg, speed_reg, phase};
  end

  // speed helpers
  logic [15:0] q16, spd_new;
  logic signed [15:0] spd_fin;
  assign q16 = drsp.quotient[15:0];
  assign spd_new = (dir > 0) ? q16 : (16'd0 - q16);
  assign spd_fin = $signed(spd_new);

  // phase helpers: constant divisions by reciprocal multiply, exact over
  // the unclamped ranges (final result at most 75)
  logic [16:0] s_neg;
  logic [15:0] s_mag;
  logic [17:0] x_pos;
  logic [36:0] rp_pos;
  logic [15:0] y_neg;
  logic [33:0] rp_neg;
  logic [12:0] z_neg;
  logic [26:0] rp_z;
  logic [6:0]  ph_mag;
  assign s_neg  = 17'd0 - {speed_before[15], speed_before};
  assign s_mag  = (speed_before > 16'sd0) ? speed_before : {1'b0, s_neg[16:2]};
  // positive: prod*3/2500
  assign x_pos  = {2'b00, prod[15:0]} + {1'b0, prod[15:0], 1'b0};
  assign rp_pos = 37'(x_pos) * 37'd429497;
  // negative: prod*4/25, then *3/100
  assign y_neg  = {prod[13:0], 2'b00};
  assign rp_neg = 34'(y_neg) * 34'd167773;
  assign z_neg  = {1'b0, ph_mid} + {ph_mid, 1'b0};
  assign rp_z   = 27'(z_neg) * 27'd10486;
  assign ph_mag = neg_s ? rp_z[26:20] : ph_mid[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      decoded_code <= '0; previous_decoded <= '0; repeat_count <= '0;
      accepted_sector <= '0; prior_sector <= '0; sector_unknown <= 1'b1;
      angle_reg <= '0; speed_reg <= '0; speed_before <= '0;
      first_run <= 1'b1; period_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          decoded_code <= dec; previous_decoded <= dec;
          repeat_count <= rep_n; accepted_sector <= acc_n;
          sector_unknown <= 1'b0; angle_reg <= ang_n;
          sect_out <= acc_n; dir <= d_w;
          if (d_w != 0) begin
            prior_sector <= acc_n;
            speed_before <= speed_reg;
            period_count <= 16'd0;
            period_use   <= 16'd0;
          end else begin
            prior_sector <= pri_n;
            period_count <= per_sat;
            period_use   <= per_sat;
            if (per_sat > stall_ticks) begin
              speed_reg <= '0;
            end else if (first_run && speed_reg != 0) begin
              speed_reg <= '0;
              first_run <= 1'b0;
            end
          end
        end
        ST_DIV: if (drsp.done) begin
          if (dir > 0 && spd_fin < 0) angle_reg <= -13'sd4;
          if (first_run && spd_fin != 0) begin
            speed_reg <= '0;
            first_run <= 1'b0;
          end else begin
            speed_reg <= spd_fin;
          end
        end
        // magnitude times period
        ST_MUL1: begin
          neg_s <= !(speed_before > 16'sd0);
          prod  <= 32'(s_mag) * 32'(period_use);
        end
        // clamp test and first scaling stage
        ST_MUL2: begin
          ph_clamp <= neg_s ? (prod >= 32'd15838) : (prod >= 32'd63334);
          ph_mid   <= neg_s ? rp_neg[33:22] : {5'd0, rp_pos[36:30]};
        end
        // final stage and sign
        ST_MUL3: begin
          if (ph_clamp) phase <= neg_s ? -8'sd75 : 8'sd75;
          else phase <= neg_s ? -$signed({1'b0, ph_mag})
                              : $signed({1'b0, ph_mag});
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/hcas_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on hcas_pkg.
module hcas_div (
  input  logic              clk,
  input  logic              rst,
  input  hcas_pkg::div_req_t req,
  output hcas_pkg::div_rsp_t rsp
);
  import hcas_pkg::*;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [PerW:0]   rem;
  logic [PerW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [PerW+1:0] trial;

  // shift in next dividend bit and try subtraction
  always_comb begin
    trial = {rem, q[NumW-1]} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q    <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        if (!trial[PerW+1]) begin
          rem <= trial[PerW:0];
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= {rem[PerW-1:0], q[NumW-1]};
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, q};
endmodule

FILE: rtl/hcas_checker.sv
// Port-level checker for the hall decoder, bound to the top level.
// Depends on the defines header.
`include "hall_commutation_angle_speed_top_defines.svh"
module hcas_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [43:0] out_data
);
  // no new sample while a result waits
  `HCAS_ASSERT_IMP(a_excl, out_valid, !in_ready)
  // a taken input leads to a busy block
  `HCAS_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready)
  // sector stays within 0..5
  `HCAS_ASSERT_IMP(a_sect, out_valid, out_data[43:41] <= 3'd5)
endmodule

bind hall_commutation_angle_speed_top hcas_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
